// ===== sv/scne_pkg.sv =====
// package for the spiking convolution neuron engine: sizes, word types,
// state and request codes, register indexes, the exp table and a small divider
// no dependencies
package scne_pkg;

  localparam int KERNEL_W = 3;
  localparam int KERNEL_H = 3;
  localparam int IN_W     = 32;
  localparam int IN_H     = 32;
  localparam int CHANNELS = 4;
  localparam int MAPS     = 4;

  localparam int OW_MAX  = IN_W + 2;
  localparam int OH_MAX  = IN_H + 2;
  localparam int NEURONS = OW_MAX * OH_MAX * MAPS;
  localparam int WEIGHTS = KERNEL_W * KERNEL_H * CHANNELS * MAPS;
  localparam int NA_W    = $clog2(NEURONS);
  localparam int WA_W    = $clog2(WEIGHTS);
  localparam int KX_W    = (KERNEL_W > 1) ? $clog2(KERNEL_W) : 1;
  localparam int KY_W    = (KERNEL_H > 1) ? $clog2(KERNEL_H) : 1;
  localparam int MP_W    = (MAPS > 1) ? $clog2(MAPS) : 1;
  localparam int CN_W    = (CHANNELS * MAPS > 1) ? $clog2(CHANNELS * MAPS) : 1;

  // potential limits, signed Q11.12
  localparam logic signed [25:0] POT_MAX = 26'sd8388607;
  localparam logic signed [25:0] POT_MIN = -26'sd8388608;

  // leak steps: one quotient bit and one table factor per bit
  localparam int          LEAK_BITS = 12;
  localparam logic [3:0]  K_TOP     = 4'(LEAK_BITS - 1);
  localparam logic [16:0] FACT_ONE  = 17'd65536;

  // configuration register indexes
  localparam logic [2:0] REG_THRESHOLD  = 3'd0;
  localparam logic [2:0] REG_BIPOLAR    = 3'd1;
  localparam logic [2:0] REG_LEAK_TIME  = 3'd2;
  localparam logic [2:0] REG_REFR_TIME  = 3'd3;
  localparam logic [2:0] REG_STRIDE_X   = 3'd4;
  localparam logic [2:0] REG_STRIDE_Y   = 3'd5;
  localparam logic [2:0] REG_PAD_X      = 3'd6;
  localparam logic [2:0] REG_PAD_Y      = 3'd7;

  typedef enum logic [1:0] {
    REQ_SPIKE  = 2'd0,
    REQ_WEIGHT = 2'd1,
    REQ_CONN   = 2'd2,
    REQ_NRST   = 2'd3
  } req_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_LOAD,
    ST_DIV,
    ST_FACT,
    ST_MAG,
    ST_UPD,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [4:0]         in_x;
    logic [4:0]         in_y;
    logic [1:0]         in_channel;
    logic [1:0]         target_map;
    logic               negative;
    logic [31:0]        spike_time;
    logic signed [15:0] write_value;
  } in_word_t;

  typedef struct packed {
    logic        fired;
    logic [1:0]  out_map;
    logic [4:0]  out_x;
    logic [4:0]  out_y;
    logic        out_negative;
    logic [31:0] out_time;
    logic        last;
  } out_word_t;

  // one neuron entry
  typedef struct packed {
    logic signed [23:0] pot;
    logic [31:0]        last_t;
    logic [31:0]        refr_end;
  } nrn_t;

  typedef struct packed {
    logic [5:0] q;
    logic [1:0] r;
  } qr_t;

  // exp(-2^(k-8)) in Q0.16
  function automatic logic [15:0] exp_bit(input logic [3:0] k);
    logic [15:0] e;
    unique case (k)
      4'd0:    e = 16'd65280;
      4'd1:    e = 16'd65026;
      4'd2:    e = 16'd64520;
      4'd3:    e = 16'd63520;
      4'd4:    e = 16'd61565;
      4'd5:    e = 16'd57835;
      4'd6:    e = 16'd51039;
      4'd7:    e = 16'd39750;
      4'd8:    e = 16'd24109;
      4'd9:    e = 16'd8869;
      4'd10:   e = 16'd1200;
      4'd11:   e = 16'd22;
      default: e = 16'd0;
    endcase
    return e;
  endfunction

  // quotient and remainder of a small value by a stride of 1, 2 or 3
  // (stride 0 acts as 1); divide by 3 is a multiply by 43/128
  function automatic qr_t div_small(input logic [5:0] v, input logic [1:0] s);
    logic [11:0] p;
    logic [5:0]  q3;
    qr_t         o;
    p  = 12'(v) * 12'd43;
    q3 = {1'b0, p[11:7]};
    unique case (s)
      2'd2: begin
        o.q = {1'b0, v[5:1]};
        o.r = {1'b0, v[0]};
      end
      2'd3: begin
        o.q = q3;
        o.r = 2'(v - (q3 << 1) - q3);
      end
      default: begin
        o.q = v;
        o.r = 2'd0;
      end
    endcase
    return o;
  endfunction

endpackage

// ===== sv/spiking_conv_neuron_engine.sv =====
// leaky integrate-and-fire convolution engine, top level
// holds the neuron, weight and connection stores and one shared multiplier
// depends on scne_pkg
//
// usage: drive in_word and raise start; the word is taken at an edge where
// start is high and busy is low. busy stays high until the request is done.
// results come out on out_word with out_strobe high for one cycle each; the
// receiver cannot stall, so every strobed word must be captured. a spike
// word gives one result per firing neuron, then a completion record with
// last set; every other request gives only the completion record.
// configuration: cfg_we, cfg_index, cfg_data write one register per edge;
// the user must write only while busy is low, the block does not enforce it.
// flow: weight and connection writes go from idle to the done state and its record. a
// spike walks all kernel offsets and maps, skipping each slot that misses;
// an updated neuron passes the load and update states with leak off, and with
// leak on also 12 divider steps, 12 table multiplies and one scaling multiply
// on the shared unit, unless the elapsed time clears the potential; then the record.
// a neuron reset request sweeps all 4624 neuron entries, then records.
// after reset the same sweep clears the memory: busy stays high throughout
// and no word is taken meanwhile.
module spiking_conv_neuron_engine (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  scne_pkg::in_word_t  in_word,
  output logic                out_strobe,
  output scne_pkg::out_word_t out_word,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [31:0]         cfg_data
);
  import scne_pkg::*;

  state_t state_r, state_nxt;

  // configuration registers
  logic [22:0] thr_r;
  logic        bip_r;
  logic [31:0] leak_r;
  logic [31:0] refr_time_r;
  logic [1:0]  stride_x_r, stride_y_r;
  logic        pad_x_r, pad_y_r;

  logic [CHANNELS*MAPS-1:0] conn_r;
  in_word_t                 item_r;
  logic [KY_W-1:0]          ky_r;
  logic [KX_W-1:0]          kx_r;
  logic [MP_W-1:0]          km_r;
  logic [NA_W-1:0]          clr_cnt_r;
  logic [31:0]              clr_time_r;
  logic                     clr_req_r;

  // memories
  nrn_t               nrn_mem [NEURONS];
  nrn_t               nrn_q;
  logic signed [15:0] wt_mem [WEIGHTS];
  logic signed [15:0] wt_q;

  logic [NA_W-1:0]    naddr_r;
  logic signed [23:0] pot_r;
  logic [39:0]        rem_r;
  logic [LEAK_BITS-1:0] q_r;
  logic [3:0]         k_r;
  logic [16:0]        factor_r;
  logic               out_strobe_r;
  out_word_t          out_word_r;
  logic [4:0]         pos_x_r, pos_y_r;

  // control decode
  logic nrn_re, nrn_we, wt_we, accept;

  // target slot evaluation
  logic [5:0]      iyp, ixp, vy, vx;
  logic [1:0]      sys, sxs;
  qr_t             qy, qx, qh, qw;
  logic            row_ok, col_ok, tgt_ok, last_tgt, spike_ok, wt_ok;
  logic [CN_W-1:0] cn_idx;
  logic [NA_W-1:0] naddr;
  logic [WA_W-1:0] waddr, wt_wa;

  always_comb begin
    iyp = 6'(item_r.in_y) + 6'(pad_y_r);
    ixp = 6'(item_r.in_x) + 6'(pad_x_r);
    sys = (stride_y_r == 2'd0) ? 2'd1 : stride_y_r;
    sxs = (stride_x_r == 2'd0) ? 2'd1 : stride_x_r;
    vy  = iyp - 6'(ky_r);
    vx  = ixp - 6'(kx_r);
    qy  = div_small(vy, sys);
    qx  = div_small(vx, sxs);
    qh  = div_small(6'(IN_H - KERNEL_H) + {4'd0, pad_y_r, 1'b0}, sys);
    qw  = div_small(6'(IN_W - KERNEL_W) + {4'd0, pad_x_r, 1'b0}, sxs);
    row_ok = (6'(ky_r) <= iyp) && (qy.r == 2'd0) && (qy.q <= qh.q);
    col_ok = (6'(kx_r) <= ixp) && (qx.r == 2'd0) && (qx.q <= qw.q);
    cn_idx = CN_W'(int'(item_r.in_channel) * MAPS + int'(km_r));
    tgt_ok = row_ok && col_ok && conn_r[cn_idx];
    naddr  = NA_W'((int'(km_r) * OH_MAX + int'(qy.q)) * OW_MAX + int'(qx.q));
    waddr  = WA_W'(((int'(km_r) * CHANNELS + int'(item_r.in_channel)) * KERNEL_H
                    + int'(ky_r)) * KERNEL_W + int'(kx_r));
    last_tgt = (ky_r == KY_W'(KERNEL_H - 1)) && (kx_r == KX_W'(KERNEL_W - 1))
               && (km_r == MP_W'(MAPS - 1));
    spike_ok = (int'(in_word.in_x) < IN_W) && (int'(in_word.in_y) < IN_H)
               && (int'(in_word.in_channel) < CHANNELS);
    wt_ok    = (int'(in_word.in_x) < KERNEL_W) && (int'(in_word.in_y) < KERNEL_H)
               && (int'(in_word.in_channel) < CHANNELS)
               && (int'(in_word.target_map) < MAPS);
    wt_wa    = WA_W'(((int'(in_word.target_map) * CHANNELS + int'(in_word.in_channel))
                      * KERNEL_H + int'(in_word.in_y)) * KERNEL_W + int'(in_word.in_x));
  end

  // leak arithmetic: clear test, divider step and the shared multiplier
  logic [31:0]        dt;
  logic               leak_clear;
  logic [43:0]        dsh, remx;
  logic [23:0]        mag, mul_a;
  logic [16:0]        mul_b;
  logic [40:0]        prod, rnd;

  always_comb begin
    dt         = item_r.spike_time - nrn_q.last_t;
    leak_clear = {4'd0, dt} >= {leak_r, 4'd0};
    dsh        = 44'(leak_r) << k_r;
    remx       = {4'd0, rem_r};
    mag        = pot_r[23] ? 24'(-pot_r) : 24'(pot_r);
    mul_a      = (state_r == ST_MAG) ? mag : 24'(factor_r);
    mul_b      = (state_r == ST_MAG) ? factor_r : {1'b0, exp_bit(k_r)};
    prod       = 41'(mul_a) * 41'(mul_b);
    rnd        = prod + 41'd32768;
  end

  // integrate, saturate and fire
  logic signed [25:0] wext, sum, sat, thr26, p_new;
  logic               fire, nsp;
  logic [22:0]        thr_eff;

  always_comb begin
    thr_eff = (thr_r == 23'd0) ? 23'd1 : thr_r;
    thr26   = signed'({3'd0, thr_eff});
    wext    = 26'(wt_q);
    sum     = 26'(pot_r) + (item_r.negative ? -wext : wext);
    if (sum > POT_MAX)      sat = POT_MAX;
    else if (sum < POT_MIN) sat = POT_MIN;
    else                    sat = sum;
    nsp  = sat < 0;
    fire = ((sat >= thr26) || (bip_r && (-sat >= thr26)))
           && (item_r.spike_time >= nrn_q.refr_end);
    p_new = fire ? (nsp ? sat + thr26 : sat - thr26) : sat;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_cnt_r == NA_W'(NEURONS - 1)) begin
        state_nxt = clr_req_r ? ST_DONE : ST_IDLE;
      end
      ST_IDLE: if (start) begin
        unique case (req_t'(in_word.req_type))
          REQ_SPIKE: state_nxt = spike_ok ? ST_SCAN : ST_DONE;
          REQ_NRST:  state_nxt = ST_CLEAR;
          default:   state_nxt = ST_DONE;
        endcase
      end
      ST_SCAN: begin
        if (tgt_ok)        state_nxt = ST_LOAD;
        else if (last_tgt) state_nxt = ST_DONE;
      end
      ST_LOAD: begin
        if (leak_r == 32'd0 || leak_clear) state_nxt = ST_UPD;
        else                               state_nxt = ST_DIV;
      end
      ST_DIV:  if (k_r == 4'd0) state_nxt = ST_FACT;
      ST_FACT: if (k_r == K_TOP) state_nxt = ST_MAG;
      ST_MAG:  state_nxt = ST_UPD;
      ST_UPD:  state_nxt = last_tgt ? ST_DONE : ST_SCAN;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy   = (state_r != ST_IDLE);
    accept = (state_r == ST_IDLE) && start;
    nrn_re = (state_r == ST_SCAN) && tgt_ok;
    nrn_we = (state_r == ST_CLEAR) || (state_r == ST_UPD);
    wt_we  = accept && (req_t'(in_word.req_type) == REQ_WEIGHT) && wt_ok;
  end

  // neuron and weight memories
  nrn_t            nrn_wd;
  logic [NA_W-1:0] nrn_wa;

  always_comb begin
    if (state_r == ST_CLEAR) begin
      nrn_wa = clr_cnt_r;
      nrn_wd = '{pot: 24'sd0, last_t: clr_time_r, refr_end: 32'd0};
    end else begin
      nrn_wa = naddr_r;
      nrn_wd = '{pot: 24'(p_new), last_t: item_r.spike_time,
                 refr_end: fire ? item_r.spike_time + refr_time_r : nrn_q.refr_end};
    end
  end

  always_ff @(posedge clk) begin
    if (nrn_we) nrn_mem[nrn_wa] <= nrn_wd;
    if (nrn_re) nrn_q <= nrn_mem[naddr];
    if (wt_we) wt_mem[wt_wa] <= in_word.write_value;
    if (nrn_re) wt_q <= wt_mem[waddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      thr_r        <= 23'd4096;
      bip_r        <= 1'b1;
      leak_r       <= 32'd0;
      refr_time_r  <= 32'd0;
      stride_x_r   <= 2'd1;
      stride_y_r   <= 2'd1;
      pad_x_r      <= 1'b0;
      pad_y_r      <= 1'b0;
      conn_r       <= '1;
      clr_cnt_r    <= '0;
      clr_time_r   <= 32'd0;
      clr_req_r    <= 1'b0;
      ky_r         <= '0;
      kx_r         <= '0;
      km_r         <= '0;
      k_r          <= 4'd0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= 1'b0;

      // register writes
      if (cfg_we) begin
        unique case (cfg_index)
          REG_THRESHOLD: thr_r       <= cfg_data[22:0];
          REG_BIPOLAR:   bip_r       <= cfg_data[0];
          REG_LEAK_TIME: leak_r      <= cfg_data;
          REG_REFR_TIME: refr_time_r <= cfg_data;
          REG_STRIDE_X:  stride_x_r  <= cfg_data[1:0];
          REG_STRIDE_Y:  stride_y_r  <= cfg_data[1:0];
          REG_PAD_X:     pad_x_r     <= cfg_data[0];
          REG_PAD_Y:     pad_y_r     <= cfg_data[0];
        endcase
      end

      // clearing sweep
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;

      // request accept
      if (accept) begin
        ky_r <= '0;
        kx_r <= '0;
        km_r <= '0;
        if (req_t'(in_word.req_type) == REQ_CONN && int'(in_word.in_channel) < CHANNELS
            && int'(in_word.target_map) < MAPS) begin
          conn_r[CN_W'(int'(in_word.in_channel) * MAPS + int'(in_word.target_map))]
            <= in_word.write_value[0];
        end
        if (req_t'(in_word.req_type) == REQ_NRST) begin
          clr_cnt_r  <= '0;
          clr_time_r <= in_word.spike_time;
          clr_req_r  <= 1'b1;
        end else begin
          clr_req_r  <= 1'b0;
        end
      end

      // slot walk: map innermost, then kernel column, then kernel row
      if ((state_r == ST_SCAN && !tgt_ok && !last_tgt)
          || (state_r == ST_UPD && !last_tgt)) begin
        if (km_r != MP_W'(MAPS - 1)) begin
          km_r <= km_r + 1'b1;
        end else begin
          km_r <= '0;
          if (kx_r != KX_W'(KERNEL_W - 1)) begin
            kx_r <= kx_r + 1'b1;
          end else begin
            kx_r <= '0;
            ky_r <= ky_r + 1'b1;
          end
        end
      end

      // leak step counter: divider counts down to 0, table walk counts back up
      if (state_r == ST_LOAD) k_r <= K_TOP;
      if (state_r == ST_DIV && k_r != 4'd0) k_r <= k_r - 1'b1;
      if (state_r == ST_FACT) k_r <= k_r + 1'b1;

      // result strobes
      if ((state_r == ST_UPD && fire) || state_r == ST_DONE) out_strobe_r <= 1'b1;
    end
  end

  // output position of the current slot, registered with the read address
  always_ff @(posedge clk) begin
    if (nrn_re) begin
      pos_x_r <= qx.q[4:0];
      pos_y_r <= qy.q[4:0];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) item_r <= in_word;
    if (nrn_re) naddr_r <= naddr;

    unique case (state_r)
      ST_LOAD: begin
        pot_r <= (leak_r != 32'd0 && leak_clear) ? 24'sd0 : nrn_q.pot;
        rem_r <= {dt, 8'd0};
      end
      ST_DIV: begin
        if (remx >= dsh) begin
          rem_r      <= 40'(remx - dsh);
          q_r[k_r]   <= 1'b1;
        end else begin
          q_r[k_r]   <= 1'b0;
        end
        factor_r <= FACT_ONE;
      end
      ST_FACT: if (q_r[k_r]) factor_r <= rnd[32:16];
      ST_MAG:  pot_r <= pot_r[23] ? -signed'(rnd[39:16]) : signed'(rnd[39:16]);
      ST_UPD: if (fire) begin
        out_word_r <= '{fired: 1'b1, out_map: 2'(km_r), out_x: pos_x_r,
                        out_y: pos_y_r, out_negative: nsp,
                        out_time: item_r.spike_time + 32'd1, last: 1'b0};
      end
      ST_DONE: begin
        out_word_r <= '{fired: 1'b0, out_map: 2'd0, out_x: 5'd0, out_y: 5'd0,
                        out_negative: 1'b0, out_time: item_r.spike_time, last: 1'b1};
      end
      default: ;
    endcase
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule

// ===== sv/scne_checker.sv =====
// port-level checks for the spiking convolution neuron engine
// depends on scne_pkg; bound to spiking_conv_neuron_engine
module scne_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_strobe,
  input scne_pkg::out_word_t out_word
);
  import scne_pkg::*;

  // reset starts the clearing sweep, so the block is busy right after it
  a_reset_busy: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("not busy after reset");

  // an accepted word always keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not make the block busy");

  // the completion record is never a firing
  a_last_not_fired: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.last) |-> !out_word.fired)
    else $error("completion record marked as firing");

  // nothing follows the completion record in the next cycle
  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.last) |=> !out_strobe)
    else $error("word right after completion record");

  // firings only come while the request is still in progress
  a_fire_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_word.fired) |-> busy)
    else $error("firing word while idle");

endmodule

bind spiking_conv_neuron_engine scne_checker u_scne_checker (.*);
